/* src/spb_pkg.sv */
package spb_pkg;

    localparam int MAX_WRITE_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH         = 4;
    localparam int FRAME_FIXED         = 7;

    localparam logic [7:0] HDR_BYTE       = 8'hFF;
    localparam logic [7:0] INSTR_READ     = 8'h02;
    localparam logic [7:0] INSTR_WRITE    = 8'h03;
    localparam logic [7:0] READ_LEN       = 8'h04;
    localparam logic [7:0] WRITE_LEN_BASE = 8'h03;
    localparam int         READ_FRAME_LEN = 8;
    localparam int         SUM_FIRST_POS  = 2;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RX    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_PARAM = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef enum logic [0:0] {
        REG_SERVO_ID     = 1'b0,
        REG_RETURN_LEVEL = 1'b1
    } reg_idx_t;

    typedef enum logic [6:0] {
        PH_HDR1  = 7'b0000001,
        PH_HDR2  = 7'b0000010,
        PH_ID    = 7'b0000100,
        PH_LEN   = 7'b0001000,
        PH_ERR   = 7'b0010000,
        PH_PARAM = 7'b0100000,
        PH_CHK   = 7'b1000000
    } rx_phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [7:0]  index;
        logic        ok;
        logic [6:0]  flags;
    } rx_item_t;

    function automatic int len_width(int max_bytes);
        return $clog2(FRAME_FIXED + max_bytes + 1);
    endfunction

    function automatic int pos_width(int max_bytes);
        return $clog2(FRAME_FIXED + max_bytes);
    endfunction

    function automatic int entry_width(int max_bytes);
        return 1 + len_width(max_bytes) + (FRAME_FIXED - 1 + max_bytes) * 8 + $bits(rx_item_t);
    endfunction

endpackage

/* src/spb_if.sv */
interface spb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] start_address;
    logic [7:0] read_count;
    logic [2:0] write_count;
    logic [7:0] data0;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [7:0] data3;
    logic [7:0] rx_byte;

    modport source (
        output valid, operation, start_address, read_count, write_count,
               data0, data1, data2, data3, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, operation, start_address, read_count, write_count,
               data0, data1, data2, data3, rx_byte,
        output ready
    );
endinterface

interface spb_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic       last;
    logic       checksum_ok;
    logic [6:0] error_flags;

    modport source (
        output valid, kind, byte_value, byte_index, last, checksum_ok, error_flags,
        input  ready
    );
    modport sink (
        input  valid, kind, byte_value, byte_index, last, checksum_ok, error_flags,
        output ready
    );
endinterface

interface spb_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/spb_front.sv */
module spb_front
    import spb_pkg::*;
#(
    parameter int  MAX_WRITE_BYTES = MAX_WRITE_BYTES_DEF,
    localparam int EW              = entry_width(MAX_WRITE_BYTES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    spb_req_if.sink       request,
    spb_cfg_if.sink       cfg,
    output logic          push,
    output logic [EW-1:0] entry,
    input  logic          push_ready
);

    localparam int LW = len_width(MAX_WRITE_BYTES);
    localparam int FB = FRAME_FIXED - 1 + MAX_WRITE_BYTES;

    typedef struct packed {
        logic                 is_tx;
        logic [LW-1:0]        len;
        logic [FB-1:0][7:0]   bytes;
        rx_item_t             rx;
    } entry_t;

    logic [7:0]  servo_id_reg;
    logic [1:0]  level_reg;
    rx_phase_t   phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  counter_reg, counter_next;
    logic [6:0]  err_reg, err_next;
    logic        armed_reg, armed_next;

    entry_t          e;
    logic            accept;
    logic            do_arm;
    logic            arm_want;
    logic [LW-1:0]   n_bytes;
    logic [3:0][7:0] wdata;
    logic [7:0]      b;
    logic [7:0]      cnt_inc;

    assign cfg.ready     = 1'b1;
    assign request.ready = push_ready;
    assign accept        = request.valid && push_ready;
    assign wdata         = {request.data3, request.data2, request.data1, request.data0};
    assign b             = request.rx_byte;
    assign cnt_inc       = counter_reg + 8'd1;
    assign entry         = e;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_id_reg <= 8'd1;
            level_reg    <= 2'd2;
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_SERVO_ID:     servo_id_reg <= cfg.data;
                REG_RETURN_LEVEL: level_reg    <= cfg.data[1:0];
            endcase
        end
    end

    always_comb
    begin
        if (request.write_count == 3'd0)
            n_bytes = LW'(1);
        else if (LW'(request.write_count) > LW'(MAX_WRITE_BYTES))
            n_bytes = LW'(MAX_WRITE_BYTES);
        else
            n_bytes = LW'(request.write_count);
    end

    always_comb
    begin
        e            = '0;
        push         = 1'b0;
        do_arm       = 1'b0;
        arm_want     = 1'b0;
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        length_next  = length_reg;
        counter_next = counter_reg;
        err_next     = err_reg;
        armed_next   = armed_reg;

        if (accept)
        begin
            unique case (request.operation)
                OP_READ:
                begin
                    push       = 1'b1;
                    e.is_tx    = 1'b1;
                    e.len      = LW'(READ_FRAME_LEN);
                    e.bytes[0] = HDR_BYTE;
                    e.bytes[1] = HDR_BYTE;
                    e.bytes[2] = servo_id_reg;
                    e.bytes[3] = READ_LEN;
                    e.bytes[4] = INSTR_READ;
                    e.bytes[5] = request.start_address;
                    e.bytes[6] = request.read_count;
                    do_arm     = 1'b1;
                    arm_want   = (level_reg != 2'd0);
                end
                OP_WRITE:
                begin
                    push       = 1'b1;
                    e.is_tx    = 1'b1;
                    e.len      = n_bytes + LW'(FRAME_FIXED);
                    e.bytes[0] = HDR_BYTE;
                    e.bytes[1] = HDR_BYTE;
                    e.bytes[2] = servo_id_reg;
                    e.bytes[3] = 8'(n_bytes) + WRITE_LEN_BASE;
                    e.bytes[4] = INSTR_WRITE;
                    e.bytes[5] = request.start_address;
                    for (int i = 0; i < MAX_WRITE_BYTES; i++)
                    begin
                        e.bytes[FRAME_FIXED - 1 + i] = (i < 4) ? wdata[i % 4] : 8'h00;
                    end
                    do_arm     = 1'b1;
                    arm_want   = level_reg[1];
                end
                OP_RX:
                begin
                    if (armed_reg)
                    begin
                        unique case (phase_reg)
                            PH_HDR1:
                            begin
                                if (b == HDR_BYTE)
                                    phase_next = PH_HDR2;
                            end
                            PH_HDR2:
                            begin
                                phase_next = (b == HDR_BYTE) ? PH_ID : PH_HDR1;
                            end
                            PH_ID:
                            begin
                                sum_next   = b;
                                phase_next = PH_LEN;
                            end
                            PH_LEN:
                            begin
                                sum_next    = sum_reg + b;
                                length_next = b;
                                phase_next  = PH_ERR;
                            end
                            PH_ERR:
                            begin
                                sum_next     = sum_reg + b;
                                err_next     = b[6:0];
                                counter_next = 8'd0;
                                phase_next   = (length_reg > 8'd2) ? PH_PARAM : PH_CHK;
                            end
                            PH_PARAM:
                            begin
                                push          = 1'b1;
                                e.rx.kind     = KIND_PARAM;
                                e.rx.value    = b;
                                e.rx.index    = counter_reg;
                                sum_next      = sum_reg + b;
                                counter_next  = cnt_inc;
                                if ({1'b0, cnt_inc} + 9'd2 >= {1'b0, length_reg})
                                    phase_next = PH_CHK;
                            end
                            PH_CHK:
                            begin
                                push       = 1'b1;
                                e.rx.kind  = KIND_END;
                                e.rx.value = b;
                                e.rx.index = counter_reg;
                                e.rx.ok    = (~sum_reg == b);
                                e.rx.flags = err_reg;
                                do_arm     = 1'b1;
                                arm_want   = 1'b0;
                            end
                            default:
                            begin
                                phase_next = PH_HDR1;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (do_arm)
        begin
            phase_next   = PH_HDR1;
            sum_next     = 8'd0;
            length_next  = 8'd0;
            counter_next = 8'd0;
            err_next     = 7'd0;
            armed_next   = arm_want;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR1;
            sum_reg     <= 8'd0;
            length_reg  <= 8'd0;
            counter_reg <= 8'd0;
            err_reg     <= 7'd0;
            armed_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            sum_reg     <= sum_next;
            length_reg  <= length_next;
            counter_reg <= counter_next;
            err_reg     <= err_next;
            armed_reg   <= armed_next;
        end
    end

endmodule

/* src/spb_queue.sv */
module spb_queue
    import spb_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign in_ready  = (count_reg != CW'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slots_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/spb_back.sv */
module spb_back
    import spb_pkg::*;
#(
    parameter int  MAX_WRITE_BYTES = MAX_WRITE_BYTES_DEF,
    localparam int EW              = entry_width(MAX_WRITE_BYTES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    output logic          head_pop,
    input  logic [EW-1:0] head,
    spb_res_if.source     result
);

    localparam int LW = len_width(MAX_WRITE_BYTES);
    localparam int PW = pos_width(MAX_WRITE_BYTES);
    localparam int FB = FRAME_FIXED - 1 + MAX_WRITE_BYTES;
    localparam int BW = $clog2(FB);

    typedef struct packed {
        logic                 is_tx;
        logic [LW-1:0]        len;
        logic [FB-1:0][7:0]   bytes;
        rx_item_t             rx;
    } entry_t;

    entry_t         h;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [7:0]     sum_reg, sum_next;
    logic           out_valid_reg, out_valid_next;
    rx_item_t       item_reg, item_next;
    logic           last_reg, last_next;
    logic           load;
    logic           emit;
    logic           at_end;

    assign h        = head;
    assign load     = !out_valid_reg || result.ready;
    assign at_end   = (LW'(pos_reg) == h.len - LW'(1));

    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        head_pop  = 1'b0;
        emit      = 1'b0;
        item_next = h.rx;
        last_next = 1'b0;

        if (head_valid && load)
        begin
            emit = 1'b1;
            if (h.is_tx)
            begin
                item_next.kind  = KIND_TX;
                item_next.index = 8'(pos_reg);
                item_next.ok    = 1'b0;
                item_next.flags = 7'd0;
                last_next       = at_end;
                if (at_end)
                begin
                    item_next.value = ~sum_reg;
                    pos_next        = '0;
                    sum_next        = 8'd0;
                    head_pop        = 1'b1;
                end
                else
                begin
                    item_next.value = h.bytes[pos_reg[BW-1:0]];
                    pos_next        = pos_reg + PW'(1);
                    if (pos_reg >= PW'(SUM_FIRST_POS))
                        sum_next = sum_reg + item_next.value;
                end
            end
            else
            begin
                head_pop = 1'b1;
            end
        end

        out_valid_next = load ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sum_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            item_reg <= item_next;
            last_reg <= last_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = item_reg.kind;
    assign result.byte_value  = item_reg.value;
    assign result.byte_index  = item_reg.index;
    assign result.last        = last_reg;
    assign result.checksum_ok = item_reg.ok;
    assign result.error_flags = item_reg.flags;

endmodule

/* src/servo_bus_packet_engine.sv */
// servo bus packet engine, master side
// request channel: one word per command or received status byte
//   read and write commands turn into a full instruction frame, one byte per result word
//   status bytes feed the reply parser; parameter bytes and the frame end come out as words
// cfg channel: index 0 servo id, index 1 status return level; always ready
// result channel: kind, byte value, index, last, checksum_ok, error flags
// path: a command's first frame byte and a status byte's result both pass through a queue
//   slot and then the output word register before they are valid
// rate: one result word per cycle while result ready is high; a read frame is 8 bytes,
//   a write frame 7 + data byte count, serialized byte by byte in the back end
// a 4-entry queue decouples the front end from the serializer, so requests keep
//   being accepted while a frame is still going out
// a result stall holds the output word and fills the queue; request ready then drops
// reset: id 1, return level 2, reply parser disarmed, queue and output empty
module servo_bus_packet_engine
    import spb_pkg::*;
#(
    parameter int MAX_WRITE_BYTES = MAX_WRITE_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    spb_req_if.sink   request,
    spb_cfg_if.sink   cfg,
    spb_res_if.source result
);

    localparam int EW = entry_width(MAX_WRITE_BYTES);

    logic          q_in_valid;
    logic          q_in_ready;
    logic [EW-1:0] q_in_data;
    logic          q_out_valid;
    logic          q_pop;
    logic [EW-1:0] q_out_data;

    spb_front #(
        .MAX_WRITE_BYTES (MAX_WRITE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .cfg        (cfg),
        .push       (q_in_valid),
        .entry      (q_in_data),
        .push_ready (q_in_ready)
    );

    spb_queue #(
        .WIDTH (EW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_pop),
        .out_data  (q_out_data)
    );

    spb_back #(
        .MAX_WRITE_BYTES (MAX_WRITE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_out_valid),
        .head_pop   (q_pop),
        .head       (q_out_data),
        .result     (result)
    );

`ifndef SYNTHESIS
    a_cmd_queued: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready
        && (request.operation == OP_READ || request.operation == OP_WRITE)
        |=> q_out_valid)
        else $error("command not queued");

    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_out_valid)
        else $error("pop from empty queue");

    a_last_only_tx: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind != KIND_TX |-> !result.last)
        else $error("last flag on status word");

    a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind == KIND_TX
        |-> !result.checksum_ok && result.error_flags == 7'd0)
        else $error("status fields set on frame byte");
`endif

endmodule
